/* src/scm_pkg.sv */
// Shared constants, types and helpers for the substring first-match block.
// Used by scm_matcher, scm_out_buf and substring_first_match; depends on nothing.
package scm_pkg;

  localparam int unsigned NeedleMax = 16;
  localparam int unsigned PosWidth  = 16;
  localparam int unsigned MatchPosW = 16;
  localparam int unsigned LenW      = 5;
  localparam int unsigned WinIdxW   = $clog2(NeedleMax);
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

  localparam logic [CfgIdxW-1:0] RegNeedleLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNeedleHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNeedleLen  = 2'd2;

  typedef struct packed {
    logic [63:0]     needle_low;
    logic [63:0]     needle_high;
    logic [LenW-1:0] needle_len;
  } cfg_t;

  typedef struct packed {
    logic                 found;
    logic [MatchPosW-1:0] match_pos;
  } result_t;

  // Clamp the programmed length into 1..NeedleMax.
  function automatic logic [LenW-1:0] eff_len(logic [LenW-1:0] n);
    logic [LenW-1:0] r;
    r = n;
    if (n == '0) r = LenW'(1);
    else if (n > LenW'(NeedleMax)) r = LenW'(NeedleMax);
    return r;
  endfunction

  // Needle byte k, byte 0 in the low bits of needle_low.
  function automatic logic [7:0] needle_byte(cfg_t c, logic [3:0] k);
    logic [7:0] r;
    if (!k[3]) r = c.needle_low[{k[2:0], 3'b000} +: 8];
    else       r = c.needle_high[{k[2:0], 3'b000} +: 8];
    return r;
  endfunction

endpackage

/* src/scm_hay_if.sv */
// Haystack input channel: valid/ready handshake with one byte per word.
// Depends on nothing.
interface scm_hay_if;
  logic       valid;
  logic       ready;
  logic [7:0] haystack_byte;
  logic       last_byte;

  modport source (output valid, output haystack_byte, output last_byte, input ready);
  modport sink   (input valid, input haystack_byte, input last_byte, output ready);
endinterface

/* src/scm_res_if.sv */
// Result output channel: valid/ready handshake with one search result per word.
// Depends on nothing.
interface scm_res_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] match_pos;

  modport source (output valid, output found, output match_pos, input ready);
  modport sink   (input valid, input found, input match_pos, output ready);
endinterface

/* src/scm_matcher.sv */
// Search state (byte window, position counter, done flag) and window compare.
// Depends on scm_pkg.
module scm_matcher import scm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [7:0]          win_q [NeedleMax];
  logic [7:0]          win_new [NeedleMax];
  logic [PosWidth-1:0] count_q, count_d;
  logic                done_q, done_d;
  logic [LenW-1:0]     len;
  logic                zero_stop;
  logic                cmp_ok;
  logic                hit;
  logic [PosWidth:0]   count_p1;
  logic [PosWidth-1:0] start;

  assign len       = eff_len(cfg_i.needle_len);
  assign zero_stop = (len >= LenW'(2)) && (byte_i == 8'd0);
  assign count_p1  = {1'b0, count_q} + (PosWidth+1)'(1);

  // Shifted window with the incoming byte as the newest entry.
  always_comb begin
    win_new[0] = byte_i;
    for (int j = 1; j < NeedleMax; j++) win_new[j] = win_q[j-1];
  end

  // Needle byte i lines up with window entry len-1-i.
  always_comb begin
    cmp_ok = 1'b1;
    for (int i = 0; i < NeedleMax; i++) begin
      if (LenW'(i) < len) begin
        if (win_new[WinIdxW'(len - LenW'(1) - LenW'(i))] != needle_byte(cfg_i, 4'(i)))
          cmp_ok = 1'b0;
      end
    end
  end

  assign hit   = (count_q < PosMax) && (count_p1 >= (PosWidth+1)'(len)) && cmp_ok;
  assign start = count_p1[PosWidth-1:0] - PosWidth'(len);

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    count_d     = count_q;
    done_d      = done_q;
    if (!done_q) begin
      if (zero_stop) begin
        res_valid_o = 1'b1;
        done_d      = 1'b1;
      end else begin
        if (count_q < PosMax) count_d = count_p1[PosWidth-1:0];
        if (hit) begin
          res_valid_o     = 1'b1;
          res_o.found     = 1'b1;
          res_o.match_pos = start[MatchPosW-1:0];
          done_d          = 1'b1;
        end else if (last_i) begin
          res_valid_o = 1'b1;
          done_d      = 1'b1;
        end
      end
    end
    res_valid_o = res_valid_o && accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NeedleMax; j++) win_q[j] <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        // End of haystack: clear for the next search.
        for (int j = 0; j < NeedleMax; j++) win_q[j] <= '0;
        count_q <= '0;
        done_q  <= 1'b0;
      end else begin
        if (!done_q && !zero_stop) begin
          for (int j = 0; j < NeedleMax; j++) win_q[j] <= win_new[j];
        end
        count_q <= count_d;
        done_q  <= done_d;
      end
    end
  end

endmodule

/* src/scm_out_buf.sv */
// Two-word result buffer that decouples the matcher from a stalled receiver.
// Depends on scm_pkg.
module scm_out_buf import scm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
      unique case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* src/substring_first_match.sv */
// Top level of the streaming substring first-match search.
// Depends on scm_pkg, scm_hay_if, scm_res_if, scm_matcher and scm_out_buf.
//
// Usage:
//   hay_i carries one haystack byte per word, with last_byte marking the
//   final byte of a haystack. res_o carries one word per search: found and
//   the start offset of the first match, or found = 0 with offset 0.
//   Program needle_low, needle_high and needle_len (indexes 0, 1, 2) through
//   the cfg_* write port while no search is in flight.
// Timing:
//   One byte is taken every cycle while the buffer has space. The window
//   compare runs on the byte as it is taken, and the result that it decides
//   is written into the output buffer, from which res_o presents it.
// Stalls:
//   Results land in a two-word buffer; hay_i.ready drops only when both
//   words are waiting, and rises again as soon as one is taken.
// Reset:
//   rst_ni clears the window, position counter, done flag and buffer; the
//   needle resets to a single zero byte.
module substring_first_match import scm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  scm_hay_if.sink             hay_i,
  scm_res_if.source           res_o
);

  cfg_t    cfg_q;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t buf_data;
  logic    space;

  // Register writes; an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.needle_low  <= '0;
      cfg_q.needle_high <= '0;
      cfg_q.needle_len  <= LenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNeedleLow:  cfg_q.needle_low  <= cfg_wdata_i;
        RegNeedleHigh: cfg_q.needle_high <= cfg_wdata_i;
        RegNeedleLen:  cfg_q.needle_len  <= cfg_wdata_i[LenW-1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  // Take a byte whenever the buffer can absorb a result.
  assign hay_i.ready = space;
  assign accept      = hay_i.valid && space;

  scm_matcher u_matcher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .byte_i      (hay_i.haystack_byte),
    .last_i      (hay_i.last_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  scm_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .space_o (space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (buf_data)
  );

  assign res_o.found     = buf_data.found;
  assign res_o.match_pos = buf_data.match_pos;

endmodule
